// ===== rtl/hsfr_pkg.sv =====
// ---------------------------------------------------------------------------
// hsfr_pkg
// Shared types and constants of the header sync frame receiver.
// ---------------------------------------------------------------------------
package hsfr_pkg;

	localparam int MAX_FRAME = 64;
	localparam int MIN_FRAME = 3;
	localparam int POS_W     = $clog2(MAX_FRAME);
	localparam int LEN_W     = $clog2(MAX_FRAME + 1);
	localparam int ADDR_W    = POS_W + 1;
	localparam int QUEUE_DEPTH = 2;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_FIRST_HEADER  = 2'd0;
	localparam logic [1:0] REG_SECOND_HEADER = 2'd1;
	localparam logic [1:0] REG_FRAME_LENGTH  = 2'd2;
	localparam logic [1:0] REG_TEST_MODE     = 2'd3;

	typedef struct packed {
		logic [7:0] first_header;
		logic [7:0] second_header;
		logic [7:0] frame_length;
		logic       test_mode;
	} cfg_t;

	// One unit of work for the back end: an echo byte or a stored frame.
	typedef struct packed {
		logic             echo;
		logic [7:0]       data;
		logic             bank;
		logic [LEN_W-1:0] len;
	} job_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	typedef struct packed {
		logic en;
		logic bank;
	} release_t;

endpackage

// ===== rtl/header_sync_frame_receiver_unit.sv =====
// ---------------------------------------------------------------------------
// header_sync_frame_receiver_unit
// Two-byte header, fixed-length frame receiver with test mode echo.
// ---------------------------------------------------------------------------
//  Channel  Direction  Contents
//  s_*      in         tdata[7:0] rx_byte
//  m_*      out        tdata[7:0] out_byte, tdata[14:8] frame_bytes;
//                      tlast last_of_frame; tuser is_echo
//  APB      in         reg 0 first_header, 1 second_header,
//                      2 frame_length, 3 test_mode (byte address 4*i)
//
//  Received bytes are taken one per cycle while the job queue has room and
//  the frame bank being filled is not still being emitted.
//  Each emitted frame byte passes the back end as a bank read, then an
//  output register load; an echo is loaded from the popped job, no bank read.
//  Two frame banks let one frame be emitted while the next is received.
//  Reset clears the hunt state, the queue and the bank busy flags.
//  A stall on the output holds the back end only; the front end keeps
//  receiving until both banks or the queue are occupied.
// ---------------------------------------------------------------------------
module header_sync_frame_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [14:8] frame_bytes, [15] zero
	output logic        m_tlast,
	output logic        m_tuser,   // [0] is_echo
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hsfr_pkg::*;

	cfg_t     cfg_q;
	logic     q_push;
	job_t     q_job;
	logic     q_full;
	logic     q_valid;
	logic     q_pop;
	job_t     q_head;
	wr_t      mem_wr;
	release_t bank_release;
	logic [1:0] bank_busy;
	logic     cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_header  <= 8'hAA;
			cfg_q.second_header <= 8'h55;
			cfg_q.frame_length  <= 8'(MAX_FRAME);
			cfg_q.test_mode     <= 1'b0;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_FIRST_HEADER:  cfg_q.first_header  <= pwdata[7:0];
				REG_SECOND_HEADER: cfg_q.second_header <= pwdata[7:0];
				REG_FRAME_LENGTH:  cfg_q.frame_length  <= pwdata[7:0];
				REG_TEST_MODE:     cfg_q.test_mode     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FIRST_HEADER:  prdata = {24'd0, cfg_q.first_header};
			REG_SECOND_HEADER: prdata = {24'd0, cfg_q.second_header};
			REG_FRAME_LENGTH:  prdata = {24'd0, cfg_q.frame_length};
			REG_TEST_MODE:     prdata = {31'd0, cfg_q.test_mode};
			default:           prdata = 32'd0;
		endcase
	end

	hsfr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (q_job),
		.mem_wr       (mem_wr),
		.bank_release (bank_release),
		.bank_busy    (bank_busy)
	);

	hsfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.full     (q_full),
		.valid    (q_valid),
		.pop      (q_pop),
		.head     (q_head)
	);

	hsfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.mem_wr       (mem_wr),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.bank_release (bank_release),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser)
	);

	// A job is never offered to a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into full queue");

	// The front end never writes a bank that is still being emitted.
	a_bank_free: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.en |-> !bank_busy[mem_wr.addr[ADDR_W-1]])
		else $error("write into busy frame bank");

	// An echo is always a single-byte run with no frame count.
	a_echo_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[14:8] == 7'd0)))
		else $error("malformed echo result");

	// A bank is only released while it is marked busy.
	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bank_release.en |-> bank_busy[bank_release.bank])
		else $error("release of idle frame bank");

endmodule

// ===== rtl/hsfr_queue.sv =====
// ---------------------------------------------------------------------------
// hsfr_queue
// Small job queue between the receive front end and the emit back end.
// ---------------------------------------------------------------------------
module hsfr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hsfr_pkg::job_t push_job,
	output logic          full,
	output logic          valid,
	input  logic          pop,
	output hsfr_pkg::job_t head
);
	import hsfr_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== rtl/hsfr_front.sv =====
// ---------------------------------------------------------------------------
// hsfr_front
// Receive front end: header hunt, byte collection into one of two frame
// banks, and job generation for echoes and completed frames.
// ---------------------------------------------------------------------------
module hsfr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  hsfr_pkg::cfg_t     cfg,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,
	input  logic               q_full,
	output logic               q_push,
	output hsfr_pkg::job_t     q_job,
	output hsfr_pkg::wr_t      mem_wr,
	input  hsfr_pkg::release_t bank_release,
	output logic [1:0]         bank_busy
);
	import hsfr_pkg::*;

	logic [POS_W-1:0] fill_q;
	logic [LEN_W-1:0] target_q;
	logic             wbank_q;
	logic [1:0]       busy_q;
	logic             accept;
	logic [LEN_W-1:0] next_count;
	logic             frame_done;
	logic [LEN_W-1:0] eff_len;
	logic [1:0]       busy_set;
	logic [1:0]       busy_clr;

	assign bank_busy  = busy_q;
	assign s_tready   = !q_full && !busy_q[wbank_q];
	assign accept     = s_tvalid && s_tready;
	assign next_count = {1'b0, fill_q} + 1'b1;

	always_comb begin
		if (cfg.frame_length > 8'(MAX_FRAME)) begin
			eff_len = LEN_W'(MAX_FRAME);
		end else if (cfg.frame_length < 8'(MIN_FRAME)) begin
			eff_len = LEN_W'(MIN_FRAME);
		end else begin
			eff_len = cfg.frame_length[LEN_W-1:0];
		end
	end

	// The collecting phase starts at position two, once both headers are in.
	assign frame_done = accept && !cfg.test_mode && (fill_q >= POS_W'(2))
		&& (next_count >= target_q);

	always_comb begin
		mem_wr.en   = 1'b0;
		mem_wr.addr = {wbank_q, fill_q};
		mem_wr.data = s_tdata;
		if (accept && !cfg.test_mode) begin
			case (fill_q)
				POS_W'(0): mem_wr.en = (s_tdata == cfg.first_header);
				POS_W'(1): mem_wr.en = (s_tdata == cfg.second_header);
				default:   mem_wr.en = 1'b1;
			endcase
		end
	end

	always_comb begin
		q_push     = (accept && cfg.test_mode) || frame_done;
		q_job.echo = cfg.test_mode;
		q_job.data = s_tdata;
		q_job.bank = wbank_q;
		q_job.len  = next_count;
	end

	assign busy_set = frame_done ? (2'b01 << wbank_q) : 2'b00;
	assign busy_clr = bank_release.en ? (2'b01 << bank_release.bank) : 2'b00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			target_q <= LEN_W'(MAX_FRAME);
			wbank_q  <= 1'b0;
			busy_q   <= 2'b00;
		end else begin
			busy_q <= (busy_q | busy_set) & ~busy_clr;
			if (accept && !cfg.test_mode) begin
				case (fill_q)
					POS_W'(0): begin
						if (s_tdata == cfg.first_header) begin
							fill_q <= POS_W'(1);
						end
					end
					POS_W'(1): begin
						if (s_tdata == cfg.second_header) begin
							fill_q   <= POS_W'(2);
							target_q <= eff_len;
						end else begin
							fill_q <= '0;
						end
					end
					default: begin
						if (frame_done) begin
							fill_q  <= '0;
							wbank_q <= !wbank_q;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				endcase
			end
		end
	end

endmodule

// ===== rtl/hsfr_back.sv =====
// ---------------------------------------------------------------------------
// hsfr_back
// Emit back end: holds the two frame banks and plays jobs out of the queue
// byte by byte into the output register.
// ---------------------------------------------------------------------------
module hsfr_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hsfr_pkg::wr_t           mem_wr,
	input  logic                    q_valid,
	input  hsfr_pkg::job_t          q_head,
	output logic                    q_pop,
	output hsfr_pkg::release_t      bank_release,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [15:0]             m_tdata,
	output logic                    m_tlast,
	output logic                    m_tuser
);
	import hsfr_pkg::*;

	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_FETCH = 2'd1;
	localparam logic [1:0] B_LOAD  = 2'd2;
	localparam logic [1:0] B_ECHO  = 2'd3;

	logic [7:0]        mem [2*MAX_FRAME];
	logic [7:0]        rdata_q;
	logic [1:0]        state_q;
	job_t              job_q;
	logic [POS_W-1:0]  idx_q;
	logic [ADDR_W-1:0] rd_addr;
	logic              out_free;
	logic              out_load;
	logic              is_last;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_last_q;
	logic              out_echo_q;

	assign rd_addr  = {job_q.bank, idx_q};
	assign out_free = !out_valid_q || m_tready;
	assign out_load = ((state_q == B_LOAD) || (state_q == B_ECHO)) && out_free;
	assign is_last  = ({1'b0, idx_q} + 1'b1) == job_q.len;
	assign q_pop    = (state_q == B_IDLE) && q_valid;

	assign bank_release.en   = (state_q == B_LOAD) && out_free && is_last;
	assign bank_release.bank = job_q.bank;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(16 - 8 - LEN_W){1'b0}}, out_len_q, out_byte_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_echo_q;

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem[mem_wr.addr] <= mem_wr.data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						idx_q   <= '0;
						state_q <= q_head.echo ? B_ECHO : B_FETCH;
					end
				end
				B_FETCH: begin
					state_q <= B_LOAD;
				end
				B_LOAD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (is_last) begin
							state_q <= B_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= B_FETCH;
						end
					end
				end
				B_ECHO: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if ((state_q == B_LOAD) && out_free) begin
			out_byte_q <= rdata_q;
			out_len_q  <= job_q.len;
			out_last_q <= is_last;
			out_echo_q <= 1'b0;
		end else if ((state_q == B_ECHO) && out_free) begin
			out_byte_q <= job_q.data;
			out_len_q  <= '0;
			out_last_q <= 1'b1;
			out_echo_q <= 1'b1;
		end
	end

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the header sync frame receiver.
// A short table of directed requests covers the header hunt, the short and
// latched frame lengths and test mode echoes. Random phases follow, each with
// its own register setting and idle pattern. Every emitted byte is compared
// with a software deframer kept in step with the accepted input bytes.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hsfr_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       echo;
		logic       last;
		logic [6:0] count;
	} frame_res_t;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [1:0] reg_idx;
		logic [7:0] value;
		logic       typed;
		frame_res_t res;
	} dir_row_t;

	localparam int NUM_ROWS     = 27;
	localparam int RANDOM_ITEMS = 400;
	localparam int SETTLE       = 16;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	header_sync_frame_receiver_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Deframer copy: registers, hunt position, latched length and frame bytes.
	cfg_t       cfg_copy;
	int         fill_pos;
	int         latched_len;
	logic [7:0] frame_copy [MAX_FRAME];

	frame_res_t pending_bytes [$];
	int         mismatches = 0;
	int         counted_items = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;

	dir_row_t   dir_rows [NUM_ROWS] = '{
		'{ROW_CFG,  REG_FRAME_LENGTH,  8'h00, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'h00, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'hAA, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'h55, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'hFF, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'hAA, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'hAA, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'h55, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'hAA, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'h55, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'h00, 1'b0, '0},
		'{ROW_CFG,  REG_FIRST_HEADER,  8'hFF, 1'b0, '0},
		'{ROW_CFG,  REG_SECOND_HEADER, 8'h00, 1'b0, '0},
		'{ROW_CFG,  REG_FRAME_LENGTH,  8'h04, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'hFF, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'h00, 1'b0, '0},
		'{ROW_CFG,  REG_FRAME_LENGTH,  8'h01, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'h80, 1'b0, '0},
		'{ROW_CFG,  REG_TEST_MODE,     8'h01, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 7'd0}},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1, 7'd0}},
		'{ROW_CFG,  REG_TEST_MODE,     8'h00, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'h7F, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'hFF, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'h00, 1'b0, '0},
		'{ROW_BYTE, REG_FIRST_HEADER,  8'h01, 1'b0, '0},
		'{ROW_CFG,  REG_FRAME_LENGTH,  8'hFF, 1'b0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int frame_len_setting();
		int len;
		len = int'(cfg_copy.frame_length);
		if (len > MAX_FRAME) len = MAX_FRAME;
		if (len < MIN_FRAME) len = MIN_FRAME;
		return len;
	endfunction

	// Advances the deframer by one byte and queues the bytes it emits.
	function automatic void deframe_byte(input logic [7:0] b);
		frame_res_t r;
		if (cfg_copy.test_mode) begin
			r = '{b, 1'b1, 1'b1, 7'd0};
			pending_bytes.push_back(r);
			return;
		end
		if (fill_pos == 0) begin
			if (b == cfg_copy.first_header) begin
				frame_copy[0] = b;
				fill_pos = 1;
			end
			return;
		end
		if (fill_pos == 1) begin
			if (b == cfg_copy.second_header) begin
				frame_copy[1] = b;
				fill_pos = 2;
				latched_len = frame_len_setting();
			end else begin
				fill_pos = 0;
			end
			return;
		end
		if (fill_pos >= MAX_FRAME) begin
			fill_pos = 0;
			return;
		end
		frame_copy[fill_pos] = b;
		fill_pos++;
		if (fill_pos < latched_len) return;
		for (int k = 0; k < fill_pos; k++) begin
			r.data  = frame_copy[k];
			r.echo  = 1'b0;
			r.last  = (k + 1 == fill_pos);
			r.count = 7'(fill_pos);
			pending_bytes.push_back(r);
		end
		fill_pos = 0;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_FIRST_HEADER:  cfg_copy.first_header  = val;
			REG_SECOND_HEADER: cfg_copy.second_header = val;
			REG_FRAME_LENGTH:  cfg_copy.frame_length  = val;
			REG_TEST_MODE:     cfg_copy.test_mode     = val[0];
			default: ;
		endcase
	endtask

	// Offers one byte and waits for it to be taken; a typed result replaces
	// the deframer output for rows whose result is known up front.
	task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
			input frame_res_t typed_res = '0);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		counted_items++;
		if (typed) pending_bytes.push_back(typed_res);
		else deframe_byte(b);
	endtask

	// Holds the sender until every queued byte has come out and the block
	// has had time to finish any byte that produces nothing.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	always @(posedge clk) begin
		frame_res_t want;
		frame_res_t got;
		m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[7:0], m_tuser, m_tlast, m_tdata[14:8]};
			if (pending_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected byte data=%h echo=%b last=%b count=%0d",
						$realtime, got.data, got.echo, got.last, got.count);
			end else begin
				want = pending_bytes.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: mismatch expected data=%h echo=%b last=%b count=%0d",
							$realtime, want.data, want.echo, want.last, want.count);
						$display("    got data=%h echo=%b last=%b count=%0d",
							got.data, got.echo, got.last, got.count);
					end
				end
			end
		end
	end

	initial begin
		int len_opts [13];
		int ph;
		int target;
		int body;
		int pick;
		logic [7:0] b;

		len_opts    = '{0, 1, 2, 3, 4, 5, 6, 8, 12, 64, 65, 200, 255};
		cfg_copy    = '{8'hAA, 8'h55, 8'd64, 1'b0};
		fill_pos    = 0;
		latched_len = MAX_FRAME;
		foreach (frame_copy[i]) frame_copy[i] = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
			end else begin
				send_byte(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].res);
			end
		end

		counted_items = 0;
		ph = 0;
		while (counted_items < RANDOM_ITEMS) begin
			wait_idle();
			send_idle_pct  = (ph % 4 == 1) ? 55 : (ph % 4 == 3) ? 24 : 0;
			recv_stall_pct = (ph % 4 == 2) ? 55 : (ph % 4 == 3) ? 24 : 0;
			if (ph == 0) pick = 12;
			else if (ph == 1) pick = 0;
			else if (ph % 5 == 4) pick = $urandom_range(9, 12);
			else pick = $urandom_range(0, 8);
			write_reg(REG_FRAME_LENGTH, 8'(len_opts[pick]));
			write_reg(REG_FIRST_HEADER, 8'($urandom));
			write_reg(REG_SECOND_HEADER, 8'($urandom));
			write_reg(REG_TEST_MODE, {7'd0, ph % 6 == 5});
			target = counted_items + 40;
			while (counted_items < target) begin
				pick = $urandom_range(99);
				if (cfg_copy.test_mode) begin
					send_byte(8'($urandom));
				end else if (pick < 75) begin
					send_byte(cfg_copy.first_header);
					send_byte(cfg_copy.second_header);
					body = frame_len_setting() - 2;
					repeat (body) send_byte(8'($urandom));
				end else if (pick < 88) begin
					// Broken header pair: the second byte never matches.
					send_byte(cfg_copy.first_header);
					b = cfg_copy.second_header ^ 8'($urandom_range(1, 255));
					send_byte(b);
				end else begin
					repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
				end
			end
			ph++;
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_bytes.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/hsfr_pkg.sv
rtl/hsfr_queue.sv
rtl/hsfr_front.sv
rtl/hsfr_back.sv
rtl/header_sync_frame_receiver_unit.sv
tb/tb.sv
